@@ rtl/core/cps_pkg.sv @@
// Shared types and constants for the close pair screening unit.
package cps_pkg;

  localparam int POS_W  = 27;
  localparam int THR_W  = 26;
  localparam int IDX_W  = 6;
  localparam int MAG_W  = POS_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int THR2_W = 2 * THR_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);

  localparam logic STATUS_PAIR = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             restart;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier_index;
    logic [IDX_W-1:0] later_index;
    logic             status;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
  } point_t;

endpackage

@@ rtl/core/close_pair_screening_unit.sv @@
// Close pair screening: point table and squared distance sequencer.
//
// Each accepted word is a 3D point. It is compared with every point already
// in the table (one table read per stored point, then three passes through a
// single shared 28x28 multiplier for dx^2, dy^2 and dz^2 and a 56-bit add and
// compare against threshold_m^2), and one result word is sent for every
// earlier point strictly closer than threshold_m, in increasing earlier index,
// the last one flagged with last_of_run. The point is then stored at the next
// index. item_ready is low until the item is done, longer for each close pair
// found and while the result side stalls. restart empties the table first. On
// a full table the point is dropped and a single status word (status 1,
// indices 0) is sent. The user must write threshold_m through cfg_data only
// while the block is idle; the block itself does not enforce this.
module close_pair_screening_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  cps_pkg::item_t         item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output cps_pkg::result_t       result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [cps_pkg::THR_W-1:0] cfg_data
);
  import cps_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FULL = 11'b00000000010,
    S_THR  = 11'b00000000100,
    S_THRW = 11'b00000001000,
    S_LOOP = 11'b00000010000,
    S_MX   = 11'b00000100000,
    S_MY   = 11'b00001000000,
    S_MZ   = 11'b00010000000,
    S_CMP  = 11'b00100000000,
    S_PUSH = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t state;
  logic [THR_W-1:0]  thr;
  logic [CW-1:0]     count;
  point_t            cur;
  point_t            rd_data;
  point_t            mem [MAX_POINTS];
  logic [AW-1:0]     n;
  logic [AW-1:0]     i;
  logic [AW-1:0]     hold;
  logic              have_hold;
  logic              last_pending;
  logic [THR2_W-1:0] thr2;
  logic [SQ_W-1:0]   prod;
  logic [SQ_W-1:0]   acc;

  logic [POS_W-1:0]  a_sel;
  logic [POS_W-1:0]  b_sel;
  logic [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mul_a;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   d2;
  logic              hit;
  logic              out_free;
  logic              send_word;
  logic [CW-1:0]     cnt_eff;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || result_ready;
  assign cnt_eff    = item.restart ? '0 : count;
  assign send_word  = out_free &&
                      (state == S_FULL || state == S_PUSH || (state == S_DONE && last_pending));

  always_comb begin
    case (state)
      S_MY: begin
        a_sel = cur.pos_y;
        b_sel = rd_data.pos_y;
      end
      S_MZ: begin
        a_sel = cur.pos_z;
        b_sel = rd_data.pos_z;
      end
      default: begin
        a_sel = cur.pos_x;
        b_sel = rd_data.pos_x;
      end
    endcase
  end

  assign diff  = {a_sel[POS_W-1], a_sel} - {b_sel[POS_W-1], b_sel};
  assign mag   = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
  assign mul_a = (state == S_THR) ? MAG_W'(thr) : mag;
  assign sq    = SQ_W'(mul_a) * SQ_W'(mul_a);
  assign d2    = acc + prod;
  assign hit   = d2 < SQ_W'(thr2);

  // point table
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      mem[n] <= cur;
    end
    rd_data <= mem[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      thr          <= THR_RESET;
      count        <= '0;
      result_valid <= 1'b0;
      have_hold    <= 1'b0;
      last_pending <= 1'b0;
      n            <= '0;
      i            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (send_word) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur.pos_x <= item.pos_x;
            cur.pos_y <= item.pos_y;
            cur.pos_z <= item.pos_z;
            count     <= cnt_eff;
            have_hold <= 1'b0;
            i         <= '0;
            n         <= AW'(cnt_eff);
            if (cnt_eff == CW'(MAX_POINTS)) begin
              state <= S_FULL;
            end else begin
              state <= S_THR;
            end
          end
        end
        S_FULL: begin
          if (out_free) begin
            result.earlier_index <= '0;
            result.later_index   <= '0;
            result.status        <= STATUS_FULL;
            result.last_of_run   <= 1'b1;
            state                <= S_IDLE;
          end
        end
        S_THR: begin
          prod  <= sq;
          state <= S_THRW;
        end
        S_THRW: begin
          thr2  <= prod[THR2_W-1:0];
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (i == n) begin
            state <= S_DONE;
          end else begin
            state <= S_MX;
          end
        end
        S_MX: begin
          prod  <= sq;
          state <= S_MY;
        end
        S_MY: begin
          acc   <= prod;
          prod  <= sq;
          state <= S_MZ;
        end
        S_MZ: begin
          acc   <= acc + prod;
          prod  <= sq;
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit && have_hold) begin
            state <= S_PUSH;
          end else begin
            if (hit) begin
              hold      <= i;
              have_hold <= 1'b1;
            end
            i     <= i + AW'(1);
            state <= S_LOOP;
          end
        end
        S_PUSH: begin
          // send the held pair, keep the new one back
          if (out_free) begin
            result.earlier_index <= IDX_W'(hold);
            result.later_index   <= IDX_W'(n);
            result.status        <= STATUS_PAIR;
            result.last_of_run   <= 1'b0;
            hold                 <= i;
            i                    <= i + AW'(1);
            state                <= S_LOOP;
          end
        end
        S_DONE: begin
          if (!last_pending) begin
            count        <= CW'(n) + CW'(1);
            last_pending <= have_hold;
            if (!have_hold) begin
              state <= S_IDLE;
            end
          end else if (out_free) begin
            result.earlier_index <= IDX_W'(hold);
            result.later_index   <= IDX_W'(n);
            result.status        <= STATUS_PAIR;
            result.last_of_run   <= 1'b1;
            last_pending         <= 1'b0;
            have_hold            <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above table depth");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_FULL |->
      result.last_of_run && result.earlier_index == '0 && result.later_index == '0)
    else $error("full-table word malformed");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_PAIR |->
      result.earlier_index < result.later_index)
    else $error("pair indices out of order");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOP || state == S_CMP |-> i <= n)
    else $error("scan index past new point");

endmodule
